FILE: sv/iale_pkg.sv
package iale_pkg;

   localparam int CAPACITY_DEFAULT = 256;

   localparam int WORD_W   = 64;
   localparam int OP_W     = 3;
   localparam int POS_W    = 9;
   localparam int COUNT_W  = 9;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OP_W-1:0] OP_SET    = 3'd1;
   localparam logic [OP_W-1:0] OP_GET    = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   localparam logic [WORD_W-1:0] QUIET_NAN = 64'h7FF8_0000_0000_0000;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_GET_WAIT,
      S_DEL_SHIFT,
      S_INS_SHIFT,
      S_INS_PUT
   } state_type;

endpackage

FILE: sv/indexed_array_list_engine.sv
// Channel    Ports                                             Handshake
// request    req_op, req_position, req_word_in                 start high, busy low
// response   rsp_status, rsp_word_out, rsp_count               rsp_valid, one cycle
//
// An operation is taken when start is high and busy is low; busy stays high until
// its response beat is on the rsp_ ports, which happens in the cycle busy falls.
// Append, set, faulting operations and unused codes answer from the decode state;
// get adds a wait state for the store read. Delete below the last element and
// insert below the count move one word per cycle through the single write port
// of the element store, and insert then writes the new word in a final state.
// Reset clears the count; store contents are only read below the count.
// The receiver cannot stall: each response beat is shown for exactly one cycle.
module indexed_array_list_engine #(
   parameter int CAPACITY = iale_pkg::CAPACITY_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [iale_pkg::OP_W-1:0]     req_op,
   input  logic [iale_pkg::POS_W-1:0]    req_position,
   input  logic [iale_pkg::WORD_W-1:0]   req_word_in,
   output logic                          rsp_valid,
   output logic [iale_pkg::STATUS_W-1:0] rsp_status,
   output logic [iale_pkg::WORD_W-1:0]   rsp_word_out,
   output logic [iale_pkg::COUNT_W-1:0]  rsp_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic                        mem_wr_en;
   logic [AW-1:0]               mem_wr_addr;
   logic [iale_pkg::WORD_W-1:0] mem_wr_data;
   logic [AW-1:0]               mem_rd_addr;
   logic [iale_pkg::WORD_W-1:0] mem_rd_data;

   iale_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_position (req_position),
      .req_word_in  (req_word_in),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_word_out (rsp_word_out),
      .rsp_count    (rsp_count),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data)
   );

   iale_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

FILE: sv/iale_mem.sv
module iale_mem #(
   parameter int DEPTH = iale_pkg::CAPACITY_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [iale_pkg::WORD_W-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [iale_pkg::WORD_W-1:0] rd_data
);

   logic [iale_pkg::WORD_W-1:0] store_mem [DEPTH];
   logic [iale_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // Read-first: a read at the address being written returns the old word.
   always_ff @(posedge clock) begin
      rd_data_ff <= store_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/iale_ctrl.sv
module iale_ctrl #(
   parameter int CAPACITY = iale_pkg::CAPACITY_DEFAULT,
   parameter int AW       = $clog2(CAPACITY),
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [iale_pkg::OP_W-1:0]     req_op,
   input  logic [iale_pkg::POS_W-1:0]    req_position,
   input  logic [iale_pkg::WORD_W-1:0]   req_word_in,
   output logic                          rsp_valid,
   output logic [iale_pkg::STATUS_W-1:0] rsp_status,
   output logic [iale_pkg::WORD_W-1:0]   rsp_word_out,
   output logic [iale_pkg::COUNT_W-1:0]  rsp_count,
   output logic                          mem_wr_en,
   output logic [AW-1:0]                 mem_wr_addr,
   output logic [iale_pkg::WORD_W-1:0]   mem_wr_data,
   output logic [AW-1:0]                 mem_rd_addr,
   input  logic [iale_pkg::WORD_W-1:0]   mem_rd_data
);

   localparam int XW = (CW > iale_pkg::POS_W) ? CW : iale_pkg::POS_W;

   iale_pkg::state_type state_ff, state_in;

   logic [iale_pkg::OP_W-1:0]     op_ff;
   logic [iale_pkg::POS_W-1:0]    pos_ff;
   logic [iale_pkg::WORD_W-1:0]   word_ff;
   logic [CW-1:0]                 count_ff, count_in;
   logic [AW-1:0]                 wr_ptr_ff, wr_ptr_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [iale_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [iale_pkg::WORD_W-1:0]   word_out_ff, word_out_in;
   logic [iale_pkg::COUNT_W-1:0]  rsp_count_ff;

   logic          accept;
   logic [XW-1:0] pos_x, cnt_x, pos_p1, wr_m1_x;
   logic [CW-1:0] cnt_m1, cnt_p1, wr_p2_x;
   logic          pos_lt, pos_eq, full, append_req;

   assign accept = start && (state_ff == iale_pkg::S_IDLE);
   assign busy   = (state_ff != iale_pkg::S_IDLE);

   assign pos_x   = XW'(pos_ff);
   assign cnt_x   = XW'(count_ff);
   assign pos_p1  = pos_x + XW'(1);
   assign wr_m1_x = XW'(wr_ptr_ff) - XW'(1);
   assign cnt_m1  = count_ff - CW'(1);
   assign cnt_p1  = count_ff + CW'(1);
   assign wr_p2_x = CW'(wr_ptr_ff) + CW'(2);
   assign pos_lt  = pos_x < cnt_x;
   assign pos_eq  = pos_x == cnt_x;
   assign full    = cnt_x == XW'(CAPACITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iale_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_op;
         pos_ff  <= req_position;
         word_ff <= req_word_in;
      end
      wr_ptr_ff    <= wr_ptr_in;
      status_ff    <= status_in;
      word_out_ff  <= word_out_in;
      rsp_count_ff <= iale_pkg::COUNT_W'(count_in);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      wr_ptr_in    = wr_ptr_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      word_out_in  = word_out_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wr_ptr_ff;
      mem_wr_data  = mem_rd_data;
      mem_rd_addr  = wr_ptr_ff;
      append_req   = 1'b0;

      unique case (state_ff)
         iale_pkg::S_IDLE: begin
            if (start) begin
               state_in = iale_pkg::S_DECODE;
            end
         end

         iale_pkg::S_DECODE: begin
            // Most operations finish here; the defaults describe a quiet ok.
            rsp_valid_in = 1'b1;
            status_in    = iale_pkg::ST_OK;
            word_out_in  = '0;
            state_in     = iale_pkg::S_IDLE;
            unique case (op_ff)
               iale_pkg::OP_APPEND: begin
                  append_req = 1'b1;
               end
               iale_pkg::OP_SET: begin
                  if (pos_eq) begin
                     append_req = 1'b1;
                  end else if (pos_lt) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = pos_x[AW-1:0];
                     mem_wr_data = word_ff;
                  end else begin
                     status_in = iale_pkg::ST_RANGE;
                  end
               end
               iale_pkg::OP_GET: begin
                  if (pos_lt) begin
                     mem_rd_addr  = pos_x[AW-1:0];
                     rsp_valid_in = 1'b0;
                     state_in     = iale_pkg::S_GET_WAIT;
                  end else begin
                     status_in   = iale_pkg::ST_RANGE;
                     word_out_in = iale_pkg::QUIET_NAN;
                  end
               end
               iale_pkg::OP_DELETE: begin
                  if (!pos_lt) begin
                     status_in = iale_pkg::ST_RANGE;
                  end else if (pos_p1 == cnt_x) begin
                     count_in = cnt_m1;
                  end else begin
                     mem_rd_addr  = pos_p1[AW-1:0];
                     wr_ptr_in    = pos_x[AW-1:0];
                     rsp_valid_in = 1'b0;
                     state_in     = iale_pkg::S_DEL_SHIFT;
                  end
               end
               iale_pkg::OP_INSERT: begin
                  if (!pos_lt && !pos_eq) begin
                     status_in = iale_pkg::ST_RANGE;
                  end else if (pos_eq) begin
                     append_req = 1'b1;
                  end else if (full) begin
                     status_in = iale_pkg::ST_FULL;
                  end else begin
                     // Shift from the top down, starting at the last element.
                     mem_rd_addr  = cnt_m1[AW-1:0];
                     wr_ptr_in    = count_ff[AW-1:0];
                     rsp_valid_in = 1'b0;
                     state_in     = iale_pkg::S_INS_SHIFT;
                  end
               end
               default: begin
               end
            endcase
            if (append_req) begin
               if (full) begin
                  status_in = iale_pkg::ST_FULL;
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = count_ff[AW-1:0];
                  mem_wr_data = word_ff;
                  count_in    = cnt_p1;
               end
            end
         end

         iale_pkg::S_GET_WAIT: begin
            rsp_valid_in = 1'b1;
            status_in    = iale_pkg::ST_OK;
            word_out_in  = mem_rd_data;
            state_in     = iale_pkg::S_IDLE;
         end

         iale_pkg::S_DEL_SHIFT: begin
            // The read data is the entry one above the write pointer.
            mem_wr_en   = 1'b1;
            mem_rd_addr = wr_p2_x[AW-1:0];
            if (wr_p2_x == count_ff) begin
               count_in     = cnt_m1;
               rsp_valid_in = 1'b1;
               status_in    = iale_pkg::ST_OK;
               word_out_in  = '0;
               state_in     = iale_pkg::S_IDLE;
            end else begin
               wr_ptr_in = wr_ptr_ff + AW'(1);
            end
         end

         iale_pkg::S_INS_SHIFT: begin
            // The read data is the entry one below the write pointer.
            mem_wr_en   = 1'b1;
            mem_rd_addr = wr_ptr_ff - AW'(2);
            if (wr_m1_x == pos_x) begin
               state_in = iale_pkg::S_INS_PUT;
            end else begin
               wr_ptr_in = wr_ptr_ff - AW'(1);
            end
         end

         iale_pkg::S_INS_PUT: begin
            mem_wr_en    = 1'b1;
            mem_wr_addr  = pos_x[AW-1:0];
            mem_wr_data  = word_ff;
            count_in     = cnt_p1;
            rsp_valid_in = 1'b1;
            status_in    = iale_pkg::ST_OK;
            word_out_in  = '0;
            state_in     = iale_pkg::S_IDLE;
         end

         default: begin
            state_in = iale_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_word_out = word_out_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

FILE: sv/iale_check.sv
module iale_check #(
   parameter int CAPACITY = iale_pkg::CAPACITY_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [iale_pkg::STATUS_W-1:0] rsp_status,
   input logic [iale_pkg::WORD_W-1:0]   rsp_word_out,
   input logic [iale_pkg::COUNT_W-1:0]  rsp_count
);

   // A taken request keeps the block busy until its response.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request taken but busy did not rise");

   // A response beat ends the operation that produced it.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response beat while still busy");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response beat without an operation in progress");

   // Full is only reported with the list at capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == iale_pkg::ST_FULL)
         |-> rsp_count == iale_pkg::COUNT_W'(CAPACITY))
      else $error("full status with count below capacity");

   a_full_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == iale_pkg::ST_FULL) |-> rsp_word_out == '0)
      else $error("full status with a nonzero word");

endmodule

bind indexed_array_list_engine iale_check #(.CAPACITY(CAPACITY)) u_iale_check (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_status   (rsp_status),
   .rsp_word_out (rsp_word_out),
   .rsp_count    (rsp_count)
);
